// File: sv/aeske_pkg.sv
// ----------------------------------------------------------------------------
// aeske_pkg: shared types, tables and microcode for the AES-128 key expansion
// Holds the S-box, the round constants, the control word layout and the
// sequencer program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aeske_pkg;

  // Number of round-key words in one run, and the index of the final word
  localparam int unsigned NumWords = 44;
  localparam int unsigned IdxW     = 6;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumWords - 1);

  // Program counter width of the sequencer
  localparam int unsigned PcW = 2;

  // Step addresses of the program
  localparam logic [PcW-1:0] StepWait = 2'd0;
  localparam logic [PcW-1:0] StepKey  = 2'd1;
  localparam logic [PcW-1:0] StepSub  = 2'd2;
  localparam logic [PcW-1:0] StepXor  = 2'd3;

  // Datapath operation of one step
  typedef enum logic [1:0] {
    OP_WAIT = 2'd0,  // take a new key
    OP_KEY  = 2'd1,  // emit a key word and rotate the window
    OP_SUB  = 2'd2,  // emit w[i-4] ^ SubWord(RotWord(w[i-1])) ^ rcon
    OP_XOR  = 2'd3   // emit w[i-4] ^ w[i-1]
  } op_t;

  // Jump condition of one step
  typedef enum logic [1:0] {
    COND_ALWAYS    = 2'd0,
    COND_ACCEPT    = 2'd1,
    COND_GROUP_END = 2'd2,  // word index at the last word of a group of four
    COND_NEVER     = 2'd3
  } cond_t;

  // One control word
  typedef struct packed {
    op_t            op;
    cond_t          cond;
    logic [PcW-1:0] target;  // taken when cond holds, else the step repeats
    logic           fin;     // return to the wait step after the final word
  } ctrl_t;

  // Sequencer program
  function automatic ctrl_t ucode_rom(input logic [PcW-1:0] pc);
    ctrl_t cw;
    unique case (pc)
      StepWait: cw = '{op: OP_WAIT, cond: COND_ACCEPT,    target: StepKey,  fin: 1'b0};
      StepKey:  cw = '{op: OP_KEY,  cond: COND_GROUP_END, target: StepSub,  fin: 1'b0};
      StepSub:  cw = '{op: OP_SUB,  cond: COND_ALWAYS,    target: StepXor,  fin: 1'b0};
      StepXor:  cw = '{op: OP_XOR,  cond: COND_GROUP_END, target: StepSub,  fin: 1'b1};
      default:  cw = '{op: OP_WAIT, cond: COND_NEVER,     target: StepWait, fin: 1'b0};
    endcase
    return cw;
  endfunction

  // Round constants, indexed by round number 1 to 10
  localparam logic [7:0] Rcon1  = 8'h01;
  localparam logic [7:0] Rcon2  = 8'h02;
  localparam logic [7:0] Rcon3  = 8'h04;
  localparam logic [7:0] Rcon4  = 8'h08;
  localparam logic [7:0] Rcon5  = 8'h10;
  localparam logic [7:0] Rcon6  = 8'h20;
  localparam logic [7:0] Rcon7  = 8'h40;
  localparam logic [7:0] Rcon8  = 8'h80;
  localparam logic [7:0] Rcon9  = 8'h1b;
  localparam logic [7:0] Rcon10 = 8'h36;

  function automatic logic [7:0] rcon_byte(input logic [3:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd1:    r = Rcon1;
      4'd2:    r = Rcon2;
      4'd3:    r = Rcon3;
      4'd4:    r = Rcon4;
      4'd5:    r = Rcon5;
      4'd6:    r = Rcon6;
      4'd7:    r = Rcon7;
      4'd8:    r = Rcon8;
      4'd9:    r = Rcon9;
      4'd10:   r = Rcon10;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Forward S-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Apply the S-box to each byte of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage : aeske_pkg

`default_nettype wire

// File: sv/aes128_key_expansion.sv
// ----------------------------------------------------------------------------
// aes128_key_expansion: AES-128 key schedule, one round-key word per cycle unless stalled
// Takes a 128-bit cipher key and streams out the 44 round-key words in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// One key item yields 44 output items, word 0 first, with tlast on word 43.
// A four-step microcode program drives a window of the last four words and a
// single SubWord path; every step after the key is taken emits one word, and
// output backpressure holds the sequencer. A new key is taken only in the
// wait step, which follows the cycle that issues word 43.
module aes128_key_expansion (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,    // [63:0] key_high, [127:64] key_low
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [39:0]       out_tdata,   // [5:0] word_index, [37:6] round_word, [39:38] zero
  output logic              out_tlast    // last_word
);
  import aeske_pkg::*;

  logic [PcW-1:0]  pc_r, pc_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [31:0]     win_r [4];
  logic [31:0]     win_nxt [4];
  logic            ovalid_r, ovalid_nxt;
  logic [IdxW-1:0] oidx_r;
  logic [31:0]     oword_r;
  logic            olast_r;

  ctrl_t       cw;
  logic        in_acc;
  logic        out_free;
  logic        emit;
  logic        advance;
  logic        group_end;
  logic        cond_hit;
  logic [31:0] prev_rot;
  logic [31:0] new_word;
  logic [31:0] emit_word;

  // Decode the current step
  assign cw        = ucode_rom(pc_r);
  assign in_tready = (cw.op == OP_WAIT);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;
  assign emit      = (cw.op != OP_WAIT) && out_free;
  assign advance   = (cw.op == OP_WAIT) ? in_acc : out_free;
  assign group_end = (idx_r[1:0] == 2'd3);

  // Evaluate the jump condition
  always_comb begin
    case (cw.cond)
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_ACCEPT:    cond_hit = in_acc;
      COND_GROUP_END: cond_hit = group_end;
      default:        cond_hit = 1'b0;
    endcase
  end

  // Compute the next expanded word
  assign prev_rot = {win_r[3][23:0], win_r[3][31:24]};
  always_comb begin
    if (cw.op == OP_SUB) begin
      new_word = win_r[0] ^ sub_word(prev_rot) ^ {rcon_byte(idx_r[5:2]), 24'h000000};
    end else begin
      new_word = win_r[0] ^ win_r[3];
    end
  end
  assign emit_word = (cw.op == OP_KEY) ? win_r[0] : new_word;

  // Sequence the program and shift the word window
  always_comb begin
    pc_nxt  = pc_r;
    idx_nxt = idx_r;
    win_nxt = win_r;
    if (advance) begin
      if (cw.fin && (idx_r == LastIdx)) begin
        pc_nxt = StepWait;
      end else if (cond_hit) begin
        pc_nxt = cw.target;
      end
    end
    unique case (cw.op)
      OP_WAIT: begin
        if (in_acc) begin
          win_nxt[0] = in_tdata[63:32];
          win_nxt[1] = in_tdata[31:0];
          win_nxt[2] = in_tdata[127:96];
          win_nxt[3] = in_tdata[95:64];
          idx_nxt    = '0;
        end
      end
      OP_KEY: begin
        if (emit) begin
          win_nxt = '{win_r[1], win_r[2], win_r[3], win_r[0]};
          idx_nxt = idx_r + IdxW'(1);
        end
      end
      OP_SUB, OP_XOR: begin
        if (emit) begin
          win_nxt = '{win_r[1], win_r[2], win_r[3], new_word};
          idx_nxt = idx_r + IdxW'(1);
        end
      end
      default: ;
    endcase
  end

  // Hold the output item until it is taken
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= StepWait;
      ovalid_r <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    win_r <= win_nxt;
    if (emit) begin
      oidx_r  <= idx_r;
      oword_r <= emit_word;
      olast_r <= (idx_r == LastIdx);
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {2'b00, oword_r, oidx_r};
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  // A taken key starts the run at word zero in the key step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (pc_r == StepKey) && (idx_r == '0))
    else $error("key accept did not start a new run");

  // The SubWord step only ever runs on the first word of a group after the key
  a_sub_align: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == StepSub) |-> (idx_r[1:0] == 2'd0) && (idx_r != '0))
    else $error("SubWord step off its group boundary");

  // The final flag goes with word 43 only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[5:0] == LastIdx)))
    else $error("last flag does not match word index");
`endif

endmodule : aes128_key_expansion

`default_nettype wire
